[sv/mvsm_pkg.sv]
// Package for the four-voice sample playback mixer.
// Holds sizing constants, command codes and register indexes.
// No dependencies.
`default_nettype none

package mvsm_pkg;

	// voices and ring sizing
	localparam int NUM_VOICES = 4;
	localparam int RING_DEPTH = 1024;

	localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int MEM_DEPTH  = NUM_VOICES * RING_DEPTH;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);

	// field widths
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 19;
	localparam int LEVEL_W    = 11;
	localparam int SUM_W      = SAMPLE_W + $clog2(NUM_VOICES);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;
	localparam int NUM_LEN_REGS = 4;
	localparam logic [CFG_IDX_W-1:0] REG_REFILL_LEVEL = 3'd4;

	localparam logic [LEVEL_W-1:0] REFILL_RESET = 11'd512;

	// mix saturation limits
	localparam logic signed [SUM_W-1:0] MIX_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] MIX_MIN = -SUM_W'(32767);

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_PUSH    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

endpackage : mvsm_pkg

`default_nettype wire

[sv/multi_voice_stream_sample_mixer.sv]
// Four-voice streaming sample mixer: per-voice rings in one shared memory,
// a sequencer that walks the voices on a tick, and one shared accumulator.
// Depends on mvsm_pkg.
`default_nettype none

//  channel   signals                                    direction  handshake
//  command   start, busy, cmd, voice, sample_in         in / out   start & !busy
//  result    done, mix_out, accepted, playing_mask,     out        done strobe
//            refill_mask
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in / out   valid & ready
//
// A trigger or push beat updates state on the accept edge and strobes its result
// in the next cycle; busy is high only in that result cycle, so no new beat is taken
// until it is out. A tick holds busy through S_READ, which does at most one memory read
// per voice through the single read port, S_DRAIN, which folds the last read word into
// the accumulator, and the result cycle in S_OUT.
// busy stays high from the accept edge through the result cycle.
// Reset clears all pointers, counts, lengths and voice flags; refill_level
// comes up at 512. The ring memory is not cleared and needs no sweep.
// The result is shown for exactly one cycle and cannot be stalled.

module multi_voice_stream_sample_mixer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command beat
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        cmd,
	input  wire logic [1:0]                        voice,
	input  wire logic signed [15:0]                sample_in,
	// result beat
	output logic                                   done,
	output logic signed [15:0]                     mix_out,
	output logic                                   accepted,
	output logic [3:0]                             playing_mask,
	output logic [3:0]                             refill_mask,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mvsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mvsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import mvsm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DRAIN,
		S_OUT
	} state_t;

	state_t state_q;

	// per-voice control state
	logic [PTR_W-1:0]   rd_ptr_q  [NUM_VOICES];
	logic [PTR_W-1:0]   wr_ptr_q  [NUM_VOICES];
	logic [FILL_W-1:0]  fill_q    [NUM_VOICES];
	logic [LEN_W-1:0]   played_q  [NUM_VOICES];
	logic [NUM_VOICES-1:0] active_q;

	// configuration registers
	logic [LEN_W-1:0]   length_q  [NUM_VOICES];
	logic [LEVEL_W-1:0] level_q;

	// sequencer and accumulator
	logic [VIDX_W-1:0]        k_q;
	logic                     take_s1;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     acc_q;

	// ring memory
	logic [SAMPLE_W-1:0] ring_mem [MEM_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;

	logic               cmd_accept;
	logic [VIDX_W-1:0]  vidx;
	logic               voice_ok;
	logic               trig_ok;
	logic               push_ok;
	logic               take;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [LEN_W-1:0]   played_inc;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [SUM_W-1:0] sum_sat;

	assign busy       = (state_q != S_IDLE);
	assign cmd_accept = start && !busy;
	assign cfg_ready  = 1'b1;

	assign vidx     = VIDX_W'(voice);
	assign voice_ok = (32'(voice) < NUM_VOICES);
	assign trig_ok  = voice_ok && (length_q[vidx] != '0);
	assign push_ok  = voice_ok && active_q[vidx] && (32'(fill_q[vidx]) < RING_DEPTH);

	// tick: voice k pops when playing and its ring holds data
	assign take       = active_q[k_q] && (fill_q[k_q] != '0);
	assign rd_en      = (state_q == S_READ) && take;
	assign rd_addr    = ADDR_W'(k_q) * ADDR_W'(RING_DEPTH) + ADDR_W'(rd_ptr_q[k_q]);
	assign played_inc = played_q[k_q] + LEN_W'(1);

	assign wr_en   = cmd_accept && (cmd_t'(cmd) == CMD_PUSH) && push_ok;
	assign wr_addr = ADDR_W'(vidx) * ADDR_W'(RING_DEPTH) + ADDR_W'(wr_ptr_q[vidx]);

	// shared adder: folds the previous cycle's read word
	assign sum_next = take_s1 ? sum_q + SUM_W'($signed(rd_data_q)) : sum_q;

	always_comb begin
		if (sum_q > MIX_MAX) begin
			sum_sat = MIX_MAX;
		end else if (sum_q < MIX_MIN) begin
			sum_sat = MIX_MIN;
		end else begin
			sum_sat = sum_q;
		end
	end

	// result beat
	assign done     = (state_q == S_OUT);
	assign mix_out  = sum_sat[SAMPLE_W-1:0];
	assign accepted = acc_q;

	always_comb begin
		playing_mask = '0;
		refill_mask  = '0;
		for (int v = 0; v < NUM_VOICES && v < 4; v++) begin
			playing_mask[v] = active_q[v];
			refill_mask[v]  = active_q[v] && (32'(fill_q[v]) < 32'(level_q));
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= sample_in;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				length_q[v] <= '0;
			end
			level_q <= REFILL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (32'(cfg_index) < NUM_LEN_REGS) begin
				if (32'(cfg_index) < NUM_VOICES) begin
					length_q[VIDX_W'(cfg_index)] <= cfg_data[LEN_W-1:0];
				end
			end else if (cfg_index == REG_REFILL_LEVEL) begin
				level_q <= cfg_data[LEVEL_W-1:0];
			end
		end
	end

	// sequencer and per-voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= '0;
			take_s1  <= 1'b0;
			sum_q    <= '0;
			acc_q    <= 1'b0;
			active_q <= '0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				rd_ptr_q[v] <= '0;
				wr_ptr_q[v] <= '0;
				fill_q[v]   <= '0;
				played_q[v] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					take_s1 <= 1'b0;
					if (cmd_accept) begin
						sum_q <= '0;
						acc_q <= 1'b0;
						k_q   <= '0;
						case (cmd_t'(cmd))
							CMD_TICK: begin
								state_q <= S_READ;
							end
							CMD_TRIGGER: begin
								state_q <= S_OUT;
								if (trig_ok) begin
									rd_ptr_q[vidx] <= '0;
									wr_ptr_q[vidx] <= '0;
									fill_q[vidx]   <= '0;
									played_q[vidx] <= '0;
									active_q[vidx] <= 1'b1;
									acc_q          <= 1'b1;
								end
							end
							CMD_PUSH: begin
								state_q <= S_OUT;
								if (push_ok) begin
									wr_ptr_q[vidx] <= (32'(wr_ptr_q[vidx]) + 1 >= RING_DEPTH)
										? '0 : wr_ptr_q[vidx] + PTR_W'(1);
									fill_q[vidx]   <= fill_q[vidx] + FILL_W'(1);
									acc_q          <= 1'b1;
								end
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_READ: begin
					sum_q   <= sum_next;
					take_s1 <= take;
					if (take) begin
						rd_ptr_q[k_q] <= (32'(rd_ptr_q[k_q]) + 1 >= RING_DEPTH)
							? '0 : rd_ptr_q[k_q] + PTR_W'(1);
						fill_q[k_q]   <= fill_q[k_q] - FILL_W'(1);
						played_q[k_q] <= played_inc;
						if (played_inc >= length_q[k_q]) begin
							active_q[k_q] <= 1'b0;
						end
					end
					if (32'(k_q) == NUM_VOICES - 1) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + VIDX_W'(1);
					end
				end
				S_DRAIN: begin
					sum_q   <= sum_next;
					take_s1 <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule : multi_voice_stream_sample_mixer

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the four-voice sample playback mixer.
// Directed and random command beats go in; each result strobe is checked field by field
// against an in-bench voice/ring predictor. Depends on mvsm_pkg and the mixer RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mvsm_pkg::*;

	localparam int MIX_LIMIT    = 32767;
	localparam int MAX_LEN      = 262144;
	localparam int STALL_LIMIT  = 2000;  // sender gaps are short
	localparam int TAIL_CYCLES  = 16;    // covers a whole tick
	localparam int RANDOM_BEATS = 550;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH0 = 3'd0;  // length_voiceN sits at index N

	typedef enum {OP_BEAT, OP_REG, OP_SETTLE} op_kind_t;

	// one queued stimulus step: a command beat, a register write, or a wait for idle
	typedef struct {
		op_kind_t                kind;
		cmd_t                    c;
		logic [1:0]              v;
		logic signed [15:0]      s;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   d;
	} stim_op_t;

	typedef struct packed {
		logic signed [15:0] mix;
		logic               acc;
		logic [3:0]         play;
		logic [3:0]         refill;
	} mix_result_t;

	// DUT signals; the inputs are known from time zero
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	cmd_t                    cmd = CMD_TICK;
	logic [1:0]              voice = '0;
	logic signed [15:0]      sample_in = '0;
	logic                    done;
	logic signed [15:0]      mix_out;
	logic                    accepted;
	logic [3:0]              playing_mask;
	logic [3:0]              refill_mask;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// predictor state: mirrors the rings, pointers, counts and registers
	logic signed [15:0]      voice_ring [NUM_VOICES][RING_DEPTH];
	logic [PTR_W-1:0]        rd_ptr     [NUM_VOICES];
	logic [PTR_W-1:0]        wr_ptr     [NUM_VOICES];
	logic [FILL_W-1:0]       ring_fill  [NUM_VOICES];
	logic [LEN_W-1:0]        played     [NUM_VOICES];
	logic                    voice_on   [NUM_VOICES];
	logic [LEN_W-1:0]        voice_len  [NUM_VOICES];
	logic [LEVEL_W-1:0]      refill_lvl;

	stim_op_t    stim_q[$];
	mix_result_t owed_results[$];   // predicted results, oldest first
	int          beat_total = 0;    // command beats queued
	int          beats_sent = 0;    // command beats accepted by the DUT
	int          results_seen = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	multi_voice_stream_sample_mixer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.voice        (voice),
		.sample_in    (sample_in),
		.done         (done),
		.mix_out      (mix_out),
		.accepted     (accepted),
		.playing_mask (playing_mask),
		.refill_mask  (refill_mask),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	task automatic clear_voices();
		for (int k = 0; k < NUM_VOICES; k++) begin
			rd_ptr[k]    = '0;
			wr_ptr[k]    = '0;
			ring_fill[k] = '0;
			played[k]    = '0;
			voice_on[k]  = 1'b0;
			voice_len[k] = '0;
		end
		refill_lvl = REFILL_RESET;
	endtask

	task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
	                             input logic [CFG_DATA_W-1:0] d);
		if (idx < NUM_LEN_REGS) begin
			if (idx < NUM_VOICES)
				voice_len[VIDX_W'(idx)] = d[LEN_W-1:0];
		end else if (idx == REG_REFILL_LEVEL) begin
			refill_lvl = d[LEVEL_W-1:0];
		end
	endtask

	// applies one accepted command beat to the voice state, queues the result it owes
	task automatic play_beat(input cmd_t op, input logic [1:0] v, input logic signed [15:0] smp);
		mix_result_t r;
		int          sum;
		int          k;
		r   = '0;
		sum = 0;
		case (op)
			CMD_TICK: begin
				for (k = 0; k < NUM_VOICES; k++) begin
					// an empty ring adds nothing and the voice does not advance
					if (voice_on[k] && ring_fill[k] != 0) begin
						sum += voice_ring[k][rd_ptr[k]];
						rd_ptr[k] = (rd_ptr[k] == RING_DEPTH - 1) ? '0 : rd_ptr[k] + 1'b1;
						ring_fill[k] = ring_fill[k] - 1'b1;
						played[k] = played[k] + 1'b1;
						// compare against the current length: a lowered length stops here
						if (played[k] >= voice_len[k])
							voice_on[k] = 1'b0;
					end
				end
				if (sum > MIX_LIMIT)
					sum = MIX_LIMIT;
				else if (sum < -MIX_LIMIT)
					sum = -MIX_LIMIT;
				r.mix = 16'(sum);
			end
			CMD_TRIGGER: begin
				// a voice with length zero has nothing loaded and ignores the trigger
				if (v < NUM_VOICES && voice_len[v] != 0) begin
					played[v]    = '0;
					rd_ptr[v]    = '0;
					wr_ptr[v]    = '0;
					ring_fill[v] = '0;
					voice_on[v]  = 1'b1;
					r.acc        = 1'b1;
				end
			end
			CMD_PUSH: begin
				// refused when idle or full
				if (v < NUM_VOICES && voice_on[v] && ring_fill[v] < RING_DEPTH) begin
					voice_ring[v][wr_ptr[v]] = smp;
					wr_ptr[v] = (wr_ptr[v] == RING_DEPTH - 1) ? '0 : wr_ptr[v] + 1'b1;
					ring_fill[v] = ring_fill[v] + 1'b1;
					r.acc = 1'b1;
				end
			end
			default: ;  // unused command: state untouched, masks still reported
		endcase
		for (k = 0; k < NUM_VOICES && k < 4; k++) begin
			if (voice_on[k]) begin
				r.play[k] = 1'b1;
				if (ring_fill[k] < refill_lvl)
					r.refill[k] = 1'b1;
			end
		end
		owed_results.push_back(r);
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	task automatic add_beat(input cmd_t c, input logic [1:0] v, input logic signed [15:0] s);
		stim_op_t op;
		op      = '{default: '0, kind: OP_BEAT, c: CMD_TICK};
		op.c    = c;
		op.v    = v;
		op.s    = s;
		stim_q.push_back(op);
		beat_total++;
	endtask

	// register writes only go out once the block has drained
	task automatic add_reg_write(input logic [CFG_IDX_W-1:0] idx, input int d);
		stim_op_t op;
		op      = '{default: '0, kind: OP_SETTLE, c: CMD_TICK};
		stim_q.push_back(op);
		op.kind = OP_REG;
		op.idx  = idx;
		op.d    = CFG_DATA_W'(d);
		stim_q.push_back(op);
	endtask

	// samples lean on the extremes so the mix saturates often
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			3:       return 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	// ---------------------------------------------------------------- driver
	// Beats and register writes come off stim_q in order. The sender idles 15% of the
	// time over the first third of the beats, 46% over the second, never in the last.

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		stim_op_t op;
		logic     beat_taken;
		logic     reg_taken;
		logic     drained;
		logic     start_nxt;
		logic     cfgv_nxt;
		int       idle_pct;
		if (!arst_n) begin
			clear_voices();
			start      <= 1'b0;
			cfg_valid  <= 1'b0;
			beats_sent <= 0;
		end else begin
			beat_taken = start && !busy;
			reg_taken  = cfg_valid && cfg_ready;
			if (beat_taken)
				play_beat(cmd, voice, sample_in);
			if (reg_taken)
				load_register(cfg_index, cfg_data);
			beats_sent <= beats_sent + (beat_taken ? 1 : 0);

			// a beat or write still waiting for its handshake holds its values
			if (!(start && !beat_taken) && !(cfg_valid && !reg_taken)) begin
				if (beats_sent * 3 < beat_total)
					idle_pct = 15;
				else if (beats_sent * 3 < beat_total * 2)
					idle_pct = 46;
				else
					idle_pct = 0;
				// idle: every beat so far has produced its result and busy is down
				drained   = !beat_taken && beats_sent == results_seen && !busy;
				start_nxt = 1'b0;
				cfgv_nxt  = 1'b0;
				if (stim_q.size() != 0) begin
					op = stim_q[0];
					case (op.kind)
						OP_BEAT: begin
							if ($urandom_range(99) >= idle_pct) begin
								start_nxt = 1'b1;
								cmd       <= op.c;
								voice     <= op.v;
								sample_in <= op.s;
								stim_q.delete(0);
							end
						end
						OP_REG: begin
							cfgv_nxt = 1'b1;
							cfg_index <= op.idx;
							cfg_data  <= op.d;
							stim_q.delete(0);
						end
						OP_SETTLE: begin
							if (drained)
								stim_q.delete(0);
						end
						default: ;
					endcase
				end
				start     <= start_nxt;
				cfg_valid <= cfgv_nxt;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// done is a one-cycle strobe; the result is taken at the edge that ends it.

	always @(posedge clk or negedge arst_n) begin : result_monitor
		mix_result_t want;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			results_seen <= results_seen + 1;
			if (owed_results.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none, actual mix_out %0d accepted %0b",
				         $time, mix_out, accepted);
			end else begin
				want = owed_results.pop_front();
				check_field("mix_out", $signed(want.mix), mix_out);
				check_field("accepted", want.acc, accepted);
				check_field("playing_mask", want.play, playing_mask);
				check_field("refill_mask", want.refill, refill_mask);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	// Counts cycles with no handshake on any channel.

	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d cycles without a handshake", $time, quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- stimulus and run control

	initial begin : run_control
		int         random_start;
		int         idx;
		int         d;
		int         r;
		logic [3:0] live;
		logic [1:0] pv;

		// --- directed: unloaded/idle refusals, saturation both ways, empty ring,
		// --- unused command, length lowered while playing
		add_reg_write(REG_LENGTH0, 3);
		add_reg_write(REG_LENGTH0 + 3'd1, MAX_LEN);
		add_reg_write(REG_LENGTH0 + 3'd2, 1);
		add_reg_write(REG_LENGTH0 + 3'd3, 0);
		add_reg_write(REG_REFILL_LEVEL, RING_DEPTH);
		add_beat(CMD_TICK, 2'd0, 16'sh0000);     // nothing playing
		add_beat(CMD_NONE, 2'd3, 16'sh7FFF);
		add_beat(CMD_TRIGGER, 2'd3, 16'sh0000);  // length zero: refused
		add_beat(CMD_PUSH, 2'd0, 16'sh1234);     // voice idle: refused
		add_beat(CMD_TRIGGER, 2'd0, 16'sh0000);
		add_beat(CMD_TRIGGER, 2'd1, 16'sh0000);
		add_beat(CMD_TRIGGER, 2'd2, 16'sh0000);
		add_beat(CMD_PUSH, 2'd0, 16'sh7FFF);
		add_beat(CMD_PUSH, 2'd1, 16'sh7FFF);
		add_beat(CMD_PUSH, 2'd2, 16'sh7FFF);
		add_beat(CMD_TICK, 2'd0, 16'sh0000);     // clips high, voice 2 ends
		add_beat(CMD_PUSH, 2'd2, 16'sh0001);     // voice 2 stopped: refused
		add_beat(CMD_PUSH, 2'd0, 16'sh8000);
		add_beat(CMD_PUSH, 2'd1, 16'sh8000);
		add_beat(CMD_TICK, 2'd1, 16'sh0000);     // clips low
		add_beat(CMD_TICK, 2'd2, 16'sh0000);     // rings empty
		add_beat(CMD_PUSH, 2'd0, 16'sh5555);
		add_beat(CMD_PUSH, 2'd1, 16'shAAAA);
		add_beat(CMD_TICK, 2'd3, 16'sh0000);     // voice 0 reaches its length
		add_reg_write(REG_LENGTH0 + 3'd1, 1);    // voice 1 already past this
		add_beat(CMD_PUSH, 2'd1, 16'sh0064);
		add_beat(CMD_TICK, 2'd0, 16'sh0000);     // voice 1 stops at this pop
		add_beat(CMD_NONE, 2'd2, 16'shAAAA);

		// --- one voice streamed: a run of pushes, drained by ticks past empty
		add_reg_write(REG_LENGTH0 + 3'd2, MAX_LEN);
		add_beat(CMD_TRIGGER, 2'd2, 16'($urandom));
		repeat (32)
			add_beat(CMD_PUSH, 2'd2, pick_sample());
		repeat (36)
			add_beat(CMD_TICK, 2'($urandom), 16'($urandom));
		repeat (4) begin
			add_beat(CMD_PUSH, 2'd2, pick_sample());
			add_beat(CMD_TICK, 2'($urandom), 16'($urandom));
		end
		add_reg_write(REG_REFILL_LEVEL, 0);

		// --- random: mostly trigger-then-play sequences, some noise, occasional
		// --- reconfiguration between phases
		random_start = beat_total;
		while (beat_total - random_start < RANDOM_BEATS) begin
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					idx = $urandom_range(4);
					if (idx == REG_REFILL_LEVEL) begin
						case ($urandom_range(3))
							0:       d = 0;
							1:       d = RING_DEPTH;
							2:       d = $urandom_range(RING_DEPTH);
							default: d = $urandom_range(24);
						endcase
					end else begin
						case ($urandom_range(7))
							0:       d = 0;
							1:       d = MAX_LEN;
							default: d = $urandom_range(1, 48);
						endcase
					end
					add_reg_write(CFG_IDX_W'(idx), d);
				end
			end
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 6))
					add_beat(cmd_t'($urandom_range(3)), 2'($urandom), 16'($urandom));
			end else begin
				live = 4'($urandom_range(1, 15));
				for (int k = 0; k < 4; k++)
					if (live[k])
						add_beat(CMD_TRIGGER, 2'(k), 16'($urandom));
				repeat ($urandom_range(4, 30)) begin
					r = $urandom_range(99);
					if (r < 50) begin
						// most pushes go to voices just triggered
						do
							pv = 2'($urandom);
						while (!live[pv] && $urandom_range(4) != 0);
						add_beat(CMD_PUSH, pv, pick_sample());
					end else if (r < 90) begin
						add_beat(CMD_TICK, 2'($urandom), 16'($urandom));
					end else if (r < 95) begin
						add_beat(CMD_TRIGGER, 2'($urandom), 16'($urandom));
					end else begin
						add_beat(cmd_t'($urandom_range(3)), 2'($urandom), 16'($urandom));
					end
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge so every clocked update has settled
		do
			@(negedge clk);
		while (stim_q.size() != 0 || start || cfg_valid || beats_sent != results_seen);
		repeat (TAIL_CYCLES) @(posedge clk);
		#1;
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (owed_results.size() != 0)
				$display("%0d expected results never arrived", owed_results.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
